// ===== design/fan_pwm_tach_controller_defines.svh =====
// Assertion macros for the fan PWM and tach controller.
`ifndef FAN_PWM_TACH_CONTROLLER_DEFINES_SVH
`define FAN_PWM_TACH_CONTROLLER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define FPTC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define FPTC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/fptc_pkg.sv =====
// Shared types and constants for the fan PWM and tach controller.
package fptc_pkg;

  localparam int PADDR_W = 5;

  localparam logic [2:0] MODE_TICK  = 3'd0;
  localparam logic [2:0] MODE_PULSE = 3'd1;
  localparam logic [2:0] MODE_SET   = 3'd2;
  localparam logic [2:0] MODE_UP    = 3'd3;
  localparam logic [2:0] MODE_DOWN  = 3'd4;

  localparam logic [2:0] REG_STEP_PCT    = 3'd0;
  localparam logic [2:0] REG_PWM_PERIOD  = 3'd1;
  localparam logic [2:0] REG_WINDOW      = 3'd2;
  localparam logic [2:0] REG_PPR         = 3'd3;
  localparam logic [2:0] REG_MAX_RPM     = 3'd4;

  localparam logic [6:0]  PCT_FULL       = 7'd100;
  localparam logic [6:0]  STALL_MIN_DUTY = 7'd5;
  localparam logic [31:0] MS_PER_MINUTE  = 32'd60000;

  // x/100 as (x*CMP_RECIP)>>CMP_SHIFT, exact for x below 2^23
  localparam logic [23:0] CMP_RECIP      = 24'd10737419;
  localparam int          CMP_SHIFT      = 30;

  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] set_value;
  } in_item_t;

  typedef struct packed {
    logic [6:0]  duty_percent;
    logic [15:0] compare_value;
    logic [15:0] speed_rpm;
    logic        stalled;
    logic        speed_updated;
  } out_item_t;

  typedef struct packed {
    logic [6:0]  step_pct;
    logic [15:0] pwm_period;
    logic [15:0] sample_window_ms;
    logic [3:0]  pulses_per_rev;
    logic [15:0] max_rpm;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_APPLY,
    ST_CMP_MUL,
    ST_WIN_GO,
    ST_WIN_WAIT,
    ST_WIN_MUL,
    ST_PPR_GO,
    ST_PPR_WAIT,
    ST_WIN_END,
    ST_CMP_SCALE,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic take;
    logic apply;
    logic cmp_mul;
    logic win_div_go;
    logic win_mul;
    logic ppr_div_go;
    logic win_end;
    logic cmp_scale;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic close_win;
    logic div_done;
  } stat_t;

endpackage

// ===== design/fptc_div.sv =====
// Radix-2 restoring divider, 32-bit dividend by 16-bit divisor, one bit per cycle.
module fptc_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [15:0] divisor,
  output logic [31:0] quotient,
  output logic        done
);

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic [31:0] quo_r, quo_nxt;
  logic [15:0] dvs_r, dvs_nxt;
  logic [16:0] rem_sh;
  logic [16:0] rem_sub;
  logic        ge;

  assign rem_sh  = {rem_r, quo_r[31]};
  assign ge      = rem_sh >= {1'b0, dvs_r};
  assign rem_sub = rem_sh - {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? rem_sub[15:0] : rem_sh[15:0];
      quo_nxt = {quo_r[30:0], ge};
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd31) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign quotient = quo_r;
  assign done     = done_r;

endmodule

// ===== design/fptc_dp.sv =====
// Datapath: duty, tach count, window timing, shared multiplier and divider, result register.
module fptc_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  fptc_pkg::cmd_t      cmd,
  output fptc_pkg::stat_t     stat,
  input  fptc_pkg::cfg_t      cfg,
  input  fptc_pkg::in_item_t  in_item,
  output fptc_pkg::out_item_t out_item
);
  import fptc_pkg::*;

  logic [2:0]  mode_r;
  logic [7:0]  setv_r;
  logic [6:0]  duty_r, duty_nxt;
  logic [15:0] pulse_r, pulse_nxt;
  logic [15:0] tick_r, tick_nxt;
  logic [31:0] speed_r, speed_nxt;
  logic        stall_r, stall_nxt;
  logic        close_r, close_nxt;
  logic        upd_r, upd_nxt;
  logic [31:0] prod_r;
  logic [15:0] cmp_r;
  out_item_t   out_r;

  logic [15:0] win_eff;
  logic [3:0]  ppr_eff;
  logic [15:0] tick_inc;
  logic [7:0]  duty_up;
  logic [6:0]  set_sat;
  logic [15:0] spd;
  logic [15:0] mul_a, mul_b;
  logic [31:0] mul_p;
  logic [46:0] cmp_prod;
  logic        div_start;
  logic [31:0] div_dividend;
  logic [15:0] div_divisor;
  logic [31:0] div_quot;
  logic        div_done;

  assign win_eff  = (cfg.sample_window_ms == 16'd0) ? 16'd1 : cfg.sample_window_ms;
  assign ppr_eff  = (cfg.pulses_per_rev == 4'd0) ? 4'd1 : cfg.pulses_per_rev;
  assign tick_inc = tick_r + 16'd1;
  assign duty_up  = {1'b0, duty_r} + {1'b0, cfg.step_pct};
  assign set_sat  = (setv_r > {1'b0, PCT_FULL}) ? PCT_FULL : setv_r[6:0];
  assign spd      = (speed_r > {16'd0, cfg.max_rpm}) ? cfg.max_rpm : speed_r[15:0];

  assign mul_a = cmd.win_mul ? pulse_r : {9'd0, duty_r};
  assign mul_b = cmd.win_mul ? div_quot[15:0] : cfg.pwm_period;
  assign mul_p = {16'd0, mul_a} * {16'd0, mul_b};

  // duty*period is at most 6553500, so 23 bits carry it
  assign cmp_prod = {24'd0, prod_r[22:0]} * {23'd0, CMP_RECIP};

  assign div_start = cmd.win_div_go | cmd.ppr_div_go;

  always_comb begin
    div_dividend = prod_r;
    div_divisor  = {12'd0, ppr_eff};
    if (cmd.win_div_go) begin
      div_dividend = MS_PER_MINUTE;
      div_divisor  = win_eff;
    end
  end

  fptc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quot),
    .done     (div_done)
  );

  always_comb begin
    duty_nxt  = duty_r;
    pulse_nxt = pulse_r;
    tick_nxt  = tick_r;
    speed_nxt = speed_r;
    stall_nxt = stall_r;
    close_nxt = close_r;
    upd_nxt   = upd_r;
    if (cmd.apply) begin
      close_nxt = 1'b0;
      upd_nxt   = 1'b0;
      case (mode_r)
        MODE_TICK: begin
          tick_nxt = tick_inc;
          if (tick_inc >= win_eff || tick_inc == 16'd0) begin
            close_nxt = 1'b1;
          end
        end
        MODE_PULSE: begin
          if (pulse_r != 16'hFFFF) begin
            pulse_nxt = pulse_r + 16'd1;
          end
        end
        MODE_SET:  duty_nxt = set_sat;
        MODE_UP:   duty_nxt = (duty_up > {1'b0, PCT_FULL}) ? PCT_FULL : duty_up[6:0];
        MODE_DOWN: duty_nxt = (duty_r >= cfg.step_pct) ? duty_r - cfg.step_pct : 7'd0;
        default: ;
      endcase
    end
    if (cmd.win_end) begin
      speed_nxt = div_quot;
      stall_nxt = (pulse_r == 16'd0) && (duty_r >= STALL_MIN_DUTY);
      pulse_nxt = '0;
      tick_nxt  = '0;
      close_nxt = 1'b0;
      upd_nxt   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      duty_r  <= '0;
      pulse_r <= '0;
      tick_r  <= '0;
      speed_r <= '0;
      stall_r <= 1'b0;
      close_r <= 1'b0;
      upd_r   <= 1'b0;
    end else begin
      duty_r  <= duty_nxt;
      pulse_r <= pulse_nxt;
      tick_r  <= tick_nxt;
      speed_r <= speed_nxt;
      stall_r <= stall_nxt;
      close_r <= close_nxt;
      upd_r   <= upd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      mode_r <= in_item.mode;
      setv_r <= in_item.set_value;
    end
    if (cmd.cmp_mul || cmd.win_mul) begin
      prod_r <= mul_p;
    end
    if (cmd.cmp_scale) begin
      cmp_r <= cmp_prod[CMP_SHIFT +: 16];
    end
    if (cmd.out_load) begin
      out_r.duty_percent  <= duty_r;
      out_r.compare_value <= cmp_r;
      out_r.speed_rpm     <= spd;
      out_r.stalled       <= stall_r;
      out_r.speed_updated <= upd_r;
    end
  end

  assign stat.close_win = close_r;
  assign stat.div_done  = div_done;
  assign out_item       = out_r;

endmodule

// ===== design/fptc_ctrl.sv =====
// Controller: sequences one transaction through the datapath and owns the result handshake.
module fptc_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  fptc_pkg::stat_t stat,
  output fptc_pkg::cmd_t  cmd
);
  import fptc_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:      if (in_valid) state_nxt = ST_APPLY;
      ST_APPLY:     state_nxt = ST_CMP_MUL;
      ST_CMP_MUL:   state_nxt = stat.close_win ? ST_WIN_GO : ST_CMP_SCALE;
      ST_WIN_GO:    state_nxt = ST_WIN_WAIT;
      ST_WIN_WAIT:  if (stat.div_done) state_nxt = ST_WIN_MUL;
      ST_WIN_MUL:   state_nxt = ST_PPR_GO;
      ST_PPR_GO:    state_nxt = ST_PPR_WAIT;
      ST_PPR_WAIT:  if (stat.div_done) state_nxt = ST_WIN_END;
      ST_WIN_END:   state_nxt = ST_CMP_MUL;
      ST_CMP_SCALE: state_nxt = ST_OUT;
      ST_OUT:       if (out_free) state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state_r)
      ST_IDLE:      cmd.take       = in_valid;
      ST_APPLY:     cmd.apply      = 1'b1;
      ST_CMP_MUL:   cmd.cmp_mul    = 1'b1;
      ST_WIN_GO:    cmd.win_div_go = 1'b1;
      ST_WIN_MUL:   cmd.win_mul    = 1'b1;
      ST_PPR_GO:    cmd.ppr_div_go = 1'b1;
      ST_WIN_END:   cmd.win_end    = 1'b1;
      ST_CMP_SCALE: cmd.cmp_scale  = 1'b1;
      ST_OUT:       cmd.out_load   = out_free;
      default:      cmd = '0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ===== design/fan_pwm_tach_controller.sv =====
// Top level: fan PWM duty and tach speed controller with APB register port.
// Sequence: an accepted event passes ST_APPLY, ST_CMP_MUL, ST_CMP_SCALE and ST_OUT; a tick
// that closes a window first runs the window states with two 32-step serial divides. One
// transaction at a time; the next is taken after ST_OUT, plus any wait there for out_ready.
// Reset: synchronous active-low rst_n clears duty, counts, speed and stall; registers
// return to their defaults. A finished result waits in an output register.
`include "fan_pwm_tach_controller_defines.svh"

module fan_pwm_tach_controller (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  fptc_pkg::in_item_t           in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output fptc_pkg::out_item_t          out_data,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [fptc_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import fptc_pkg::*;

  cfg_t       cfg_r, cfg_nxt;
  logic       wr_en;
  logic [2:0] reg_idx;
  cmd_t       cmd;
  stat_t      stat;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[PADDR_W-1:2];

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx)
        REG_STEP_PCT:   cfg_nxt.step_pct         = pwdata[6:0];
        REG_PWM_PERIOD: cfg_nxt.pwm_period       = pwdata[15:0];
        REG_WINDOW:     cfg_nxt.sample_window_ms = pwdata[15:0];
        REG_PPR:        cfg_nxt.pulses_per_rev   = pwdata[3:0];
        REG_MAX_RPM:    cfg_nxt.max_rpm          = pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.step_pct         <= 7'd5;
      cfg_r.pwm_period       <= 16'd1000;
      cfg_r.sample_window_ms <= 16'd1000;
      cfg_r.pulses_per_rev   <= 4'd2;
      cfg_r.max_rpm          <= 16'd10000;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    case (reg_idx)
      REG_STEP_PCT:   prdata = {25'd0, cfg_r.step_pct};
      REG_PWM_PERIOD: prdata = {16'd0, cfg_r.pwm_period};
      REG_WINDOW:     prdata = {16'd0, cfg_r.sample_window_ms};
      REG_PPR:        prdata = {28'd0, cfg_r.pulses_per_rev};
      REG_MAX_RPM:    prdata = {16'd0, cfg_r.max_rpm};
      default:        prdata = '0;
    endcase
  end

  fptc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  fptc_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .stat     (stat),
    .cfg      (cfg_r),
    .in_item  (in_data),
    .out_item (out_data)
  );

  `FPTC_ASSERT_IMP(a_duty_range, out_valid, out_data.duty_percent <= PCT_FULL, "duty above 100")
  `FPTC_ASSERT_IMP(a_stall, out_valid && out_data.stalled, ~|out_data.speed_rpm, "stall speed")
  `FPTC_ASSERT_NXT(a_one_busy, in_valid && in_ready, !in_ready, "taken while busy")

endmodule

// ===== tb/sv/fan_event_checker.sv =====
`timescale 1ns / 1ps
// Fan controller checker: tracks register writes, predicts each event's report, compares.
module fan_event_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  fptc_pkg::in_item_t           in_data,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  fptc_pkg::out_item_t          out_data,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [fptc_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  input  logic                         pready,
  output int unsigned                  errors,
  output int unsigned                  pending
);
  import fptc_pkg::*;

  cfg_t        regs;
  logic [6:0]  duty;
  logic [15:0] pulses;
  logic [15:0] ticks;
  logic [31:0] speed;
  logic        stall;

  out_item_t   expected_reports[$];
  int unsigned fail_count = 0;

  function automatic out_item_t advance_fan(input in_item_t ev);
    logic [15:0] win;
    logic [3:0]  ppr;
    logic [7:0]  raised;
    out_item_t   rep;
    win = (regs.sample_window_ms == '0) ? 16'd1 : regs.sample_window_ms;
    ppr = (regs.pulses_per_rev == '0) ? 4'd1 : regs.pulses_per_rev;
    raised = {1'b0, duty} + {1'b0, regs.step_pct};
    rep.speed_updated = 1'b0;
    case (ev.mode)
      MODE_TICK: begin
        ticks = ticks + 16'd1;
        if (ticks >= win || ticks == '0) begin
          if (pulses == '0) begin
            speed = '0;
            stall = (duty >= STALL_MIN_DUTY);
          end else begin
            speed = (32'(pulses) * (MS_PER_MINUTE / 32'(win))) / 32'(ppr);
            stall = 1'b0;
          end
          pulses = '0;
          ticks = '0;
          rep.speed_updated = 1'b1;
        end
      end
      MODE_PULSE: begin
        if (pulses != 16'hFFFF) pulses = pulses + 16'd1;
      end
      MODE_SET: begin
        duty = (ev.set_value > 8'(PCT_FULL)) ? PCT_FULL : ev.set_value[6:0];
      end
      MODE_UP: begin
        duty = (raised > 8'(PCT_FULL)) ? PCT_FULL : raised[6:0];
      end
      MODE_DOWN: begin
        duty = (duty >= regs.step_pct) ? duty - regs.step_pct : '0;
      end
      default: ;
    endcase
    rep.duty_percent = duty;
    rep.compare_value = 16'((32'(duty) * 32'(regs.pwm_period)) / 32'(PCT_FULL));
    rep.speed_rpm = (speed > 32'(regs.max_rpm)) ? regs.max_rpm : speed[15:0];
    rep.stalled = stall;
    return rep;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (want_v !== got_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : watch
    out_item_t want;
    if (!rst_n) begin
      regs.step_pct = 7'd5;
      regs.pwm_period = 16'd1000;
      regs.sample_window_ms = 16'd1000;
      regs.pulses_per_rev = 4'd2;
      regs.max_rpm = 16'd10000;
      duty = '0;
      pulses = '0;
      ticks = '0;
      speed = '0;
      stall = 1'b0;
      expected_reports.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[PADDR_W-1:2])
          REG_STEP_PCT:   regs.step_pct = pwdata[6:0];
          REG_PWM_PERIOD: regs.pwm_period = pwdata[15:0];
          REG_WINDOW:     regs.sample_window_ms = pwdata[15:0];
          REG_PPR:        regs.pulses_per_rev = pwdata[3:0];
          REG_MAX_RPM:    regs.max_rpm = pwdata[15:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_reports.size() == 0) begin
          $error("fan report with no event outstanding: %h", out_data);
          fail_count++;
        end else begin
          want = expected_reports.pop_front();
          check_field("duty_percent", 32'(want.duty_percent), 32'(out_data.duty_percent));
          check_field("compare_value", 32'(want.compare_value),
                      32'(out_data.compare_value));
          check_field("speed_rpm", 32'(want.speed_rpm), 32'(out_data.speed_rpm));
          check_field("stalled", 32'(want.stalled), 32'(out_data.stalled));
          check_field("speed_updated", 32'(want.speed_updated),
                      32'(out_data.speed_updated));
        end
      end
      if (in_valid && in_ready) expected_reports.push_back(advance_fan(in_data));
    end
    errors <= fail_count;
    pending <= expected_reports.size();
  end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// Testbench top: drives fan events and register writes, then reports the verdict.
module testbench;
  import fptc_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam int unsigned PHASES        = 12;
  localparam int unsigned PHASE_EVENTS  = 70;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned SETTLE_CYCLES = 150;

  localparam logic [2:0] MODE_SPARE_A = 3'd5;
  localparam logic [2:0] MODE_SPARE_B = 3'd6;
  localparam logic [2:0] MODE_SPARE_C = 3'd7;
  localparam logic [2:0] REG_SPARE_A  = 3'd5;
  localparam logic [2:0] REG_SPARE_C  = 3'd7;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  in_item_t           in_data = '0;
  logic               in_ready;
  logic               out_valid;
  logic               out_ready = 1'b0;
  out_item_t          out_data;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  logic        hold_req = 1'b0;
  logic        hold_req_q = 1'b0;
  int unsigned hold_left = 0;
  int unsigned cycle_count = 0;
  int unsigned errors;
  int unsigned pending;

  always #2 clk = ~clk;

  fan_pwm_tach_controller dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  fan_event_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .pready    (pready),
    .errors    (errors),
    .pending   (pending)
  );

  // receiver: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    hold_req_q <= hold_req;
    if (hold_req && !hold_req_q) begin
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  task automatic send_event(input logic [2:0] mode, input logic [7:0] setv);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data.mode <= mode;
    in_data.set_value <= setv;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic reg_write(input logic [2:0] idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // upper bits carry junk so the register masking is exercised
  task automatic set_fan_regs(input logic [6:0] step, input logic [15:0] period,
                              input logic [15:0] window, input logic [3:0] ppr,
                              input logic [15:0] cap);
    reg_write(REG_STEP_PCT, {25'($urandom), step});
    reg_write(REG_PWM_PERIOD, {16'($urandom), period});
    reg_write(REG_WINDOW, {16'($urandom), window});
    reg_write(REG_PPR, {28'($urandom), ppr});
    reg_write(REG_MAX_RPM, {16'($urandom), cap});
  endtask

  initial begin : stimulus
    logic [2:0]  mode;
    logic [7:0]  setv;
    logic [15:0] window;
    logic [15:0] cap;
    int unsigned roll;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: saturation, window of zero, zero ppr, clamps, stall threshold
    set_fan_regs(7'd100, 16'hFFFF, 16'd0, 4'd0, 16'hFFFF);
    reg_write(REG_SPARE_A, $urandom);
    reg_write(REG_SPARE_C, $urandom);
    send_event(MODE_SET, 8'd255);
    send_event(MODE_UP, 8'($urandom));
    send_event(MODE_DOWN, 8'($urandom));
    send_event(MODE_DOWN, 8'($urandom));
    send_event(MODE_SET, 8'd100);
    send_event(MODE_PULSE, 8'($urandom));
    send_event(MODE_PULSE, 8'($urandom));
    send_event(MODE_TICK, 8'($urandom));
    send_event(MODE_TICK, 8'($urandom));
    send_event(MODE_SPARE_A, 8'd255);
    send_event(MODE_SPARE_B, 8'd0);
    send_event(MODE_SPARE_C, 8'($urandom));
    send_event(MODE_SET, 8'd4);
    send_event(MODE_TICK, 8'($urandom));
    send_event(MODE_SET, 8'd5);
    send_event(MODE_TICK, 8'($urandom));
    settle();
    set_fan_regs(7'd0, 16'd0, 16'd3, 4'd8, 16'd0);
    send_event(MODE_UP, 8'($urandom));
    send_event(MODE_TICK, 8'($urandom));
    send_event(MODE_TICK, 8'($urandom));
    settle();
    // shrink the window below the ticks already counted
    reg_write(REG_WINDOW, 32'd1);
    send_event(MODE_PULSE, 8'($urandom));
    send_event(MODE_TICK, 8'($urandom));
    send_event(MODE_SET, 8'd101);
    send_event(MODE_SET, 8'd0);
    send_event(MODE_DOWN, 8'($urandom));
    settle();

    for (int p = 0; p < PHASES; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
        1: begin send_idle_pct = 72; recv_stall_pct <= 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct <= 72; end
        default: begin send_idle_pct = 38; recv_stall_pct <= 38; end
      endcase
      if (p == 0) begin
        set_fan_regs(7'd1, 16'd1, 16'd1, 4'd1, 16'hFFFF);
      end else if (p == PHASES - 1) begin
        set_fan_regs(7'd127, 16'hFFFF, 16'd60000, 4'd15, 16'd0);
      end else begin
        roll = $urandom_range(99);
        if (roll < 10) window = 16'd0;
        else if (roll < 90) window = 16'($urandom_range(1, 12));
        else window = 16'($urandom_range(13, 200));
        roll = $urandom_range(99);
        if (roll < 20) cap = 16'd0;
        else if (roll < 50) cap = 16'hFFFF;
        else cap = 16'($urandom);
        set_fan_regs(7'($urandom), 16'($urandom), window, 4'($urandom), cap);
      end
      if (p == 0) hold_req <= 1'b1;

      for (int i = 0; i < PHASE_EVENTS; i++) begin
        roll = $urandom_range(99);
        if (roll < 36) mode = MODE_TICK;
        else if (roll < 72) mode = MODE_PULSE;
        else if (roll < 82) mode = MODE_SET;
        else if (roll < 89) mode = MODE_UP;
        else if (roll < 96) mode = MODE_DOWN;
        else mode = 3'($urandom_range(MODE_SPARE_A, MODE_SPARE_C));
        if ($urandom_range(99) < 70) setv = 8'($urandom_range(0, PCT_FULL));
        else setv = 8'($urandom);
        send_event(mode, setv);
      end
      settle();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) $display("testbench passed");
    else $display("testbench failed");
    $finish;
  end

endmodule
